// ----- design/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg - shared types and constants for the SHA-256 digest block
// Controller states, datapath command word, round constants and initial hash.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned NumWords    = 8;
    localparam int unsigned WindowWords = 16;
    localparam int unsigned NumRounds   = 64;

    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic      shift_byte;
        byte_src_t src;
        logic [2:0] len_sel;
        logic      count_byte;
        logic      round_en;
        logic [5:0] round_idx;
        logic      update_chain;
        logic      finish;
    } cmd_t;

    function automatic logic [31:0] initial_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            3'd7:    v = 32'h5be0cd19;
            default: v = 32'h6a09e667;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h428a2f98;
        endcase
        return k;
    endfunction

endpackage

// ----- design/sha_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha_ctrl - SHA-256 sequencing controller
// Tracks block fill, padding and round count; drives datapath commands.
// ----------------------------------------------------------------------------
module sha_ctrl
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic byte_present,
    input  logic end_of_message,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [5:0] bib_reg, bib_next;        // bytes in open block
    logic [5:0] rnd_reg, rnd_next;
    logic       pad_active_reg, pad_active_next;
    logic       pad_first_reg, pad_first_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       pad_done;

    assign out_free = !out_valid_reg || !out_stall;
    assign pad_done = !pad_first_reg && (bib_reg == 6'd56);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            bib_reg        <= '0;
            rnd_reg        <= '0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bib_reg        <= bib_next;
            rnd_reg        <= rnd_next;
            pad_active_reg <= pad_active_next;
            pad_first_reg  <= pad_first_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next      = state_reg;
        bib_next        = bib_reg;
        rnd_next        = rnd_reg;
        pad_active_next = pad_active_reg;
        pad_first_next  = pad_first_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        bib_next = bib_reg + 6'd1;
                    end
                    if (byte_present && (bib_reg == 6'd63))
                    begin
                        state_next      = ST_ROUND;
                        rnd_next        = '0;
                        pad_active_next = end_of_message;
                        pad_first_next  = end_of_message;
                    end
                    else if (end_of_message)
                    begin
                        state_next      = ST_PAD;
                        pad_active_next = 1'b1;
                        pad_first_next  = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_done)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    pad_first_next = 1'b0;
                    bib_next       = bib_reg + 6'd1;
                    if (bib_reg == 6'd63)
                    begin
                        state_next = ST_ROUND;
                        rnd_next   = '0;
                    end
                end
            end
            ST_LEN:
            begin
                bib_next = bib_reg + 6'd1;
                if (bib_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                    last_next  = 1'b1;
                end
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (last_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_COLLECT;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    last_next       = 1'b0;
                    pad_active_next = 1'b0;
                    pad_first_next  = 1'b0;
                    bib_next        = '0;
                    state_next      = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.src  = SRC_INPUT;
        in_stall = 1'b1;

        case (state_reg)
            ST_COLLECT:
            begin
                in_stall       = 1'b0;
                cmd.shift_byte = in_valid && byte_present;
                cmd.count_byte = in_valid && byte_present;
            end
            ST_PAD:
            begin
                cmd.shift_byte = !pad_done;
                cmd.src        = pad_first_reg ? SRC_PAD : SRC_ZERO;
            end
            ST_LEN:
            begin
                cmd.shift_byte = 1'b1;
                cmd.src        = SRC_LEN;
                cmd.len_sel    = bib_reg[2:0];
            end
            ST_ROUND:
            begin
                cmd.round_en  = 1'b1;
                cmd.round_idx = rnd_reg;
            end
            ST_UPDATE:
            begin
                cmd.update_chain = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- design/sha_datapath.sv -----
// ----------------------------------------------------------------------------
// sha_datapath - SHA-256 block window, round logic and chaining state
// Bytes shift into a 16-word window that doubles as the message schedule.
// ----------------------------------------------------------------------------
module sha_datapath
    import sha_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [7:0]           data_byte,
    output logic [7:0][31:0]     digest
);

    logic [31:0] win_reg   [WindowWords];
    logic [31:0] win_next  [WindowWords];
    logic [31:0] work_reg  [NumWords];
    logic [31:0] work_next [NumWords];
    logic [31:0] chain_reg [NumWords];
    logic [31:0] chain_next[NumWords];
    logic [7:0][31:0] digest_reg, digest_next;
    logic [60:0] cnt_reg, cnt_next;       // message length in bytes

    logic [63:0] len_bits;
    logic [7:0]  new_byte;
    logic [31:0] sched_word;
    logic [31:0] t1, t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign len_bits = {cnt_reg, 3'b000};

    // byte source select
    always_comb
    begin
        logic [63:0] sh;
        sh = len_bits << {cmd.len_sel, 3'b000};
        case (cmd.src)
            SRC_INPUT: new_byte = data_byte;
            SRC_PAD:   new_byte = PadByte;
            SRC_ZERO:  new_byte = 8'h00;
            SRC_LEN:   new_byte = sh[63:56];
            default:   new_byte = 8'h00;
        endcase
    end

    // schedule word and round terms
    always_comb
    begin
        logic [31:0] a, b, c, e, f, g, h;
        logic [31:0] bs0, bs1, ch, maj, ss0, ss1;
        a = work_reg[0];
        b = work_reg[1];
        c = work_reg[2];
        e = work_reg[4];
        f = work_reg[5];
        g = work_reg[6];
        h = work_reg[7];
        ss0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        ss1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        sched_word = ss1 + win_reg[9] + ss0 + win_reg[0];
        bs1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch  = (e & f) ^ (~e & g);
        t1  = h + bs1 + ch + round_const(cmd.round_idx) + win_reg[0];
        bs0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        maj = (a & b) ^ (a & c) ^ (b & c);
        t2  = bs0 + maj;
    end

    // window: byte shift while filling, word shift while running rounds
    always_comb
    begin
        for (int i = 0; i < WindowWords; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (cmd.shift_byte)
        begin
            for (int i = 0; i < WindowWords - 1; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[WindowWords-1] = {win_reg[WindowWords-1][23:0], new_byte};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < WindowWords - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WindowWords-1] = sched_word;
        end
    end

    // working variables, chaining state, length, digest
    always_comb
    begin
        for (int i = 0; i < NumWords; i++)
        begin
            work_next[i]  = work_reg[i];
            chain_next[i] = chain_reg[i];
        end
        digest_next = digest_reg;
        cnt_next    = cnt_reg;

        if (cmd.count_byte)
        begin
            cnt_next = cnt_reg + 61'd1;
        end

        if (cmd.finish)
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                digest_next[i] = chain_reg[i];
                chain_next[i]  = initial_hash(3'(i));
                work_next[i]   = initial_hash(3'(i));
            end
            cnt_next = '0;
        end
        else if (cmd.update_chain)
        begin
            // working copy is left equal to the new chain for the next block
            for (int i = 0; i < NumWords; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
                work_next[i]  = chain_reg[i] + work_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                chain_reg[i] <= initial_hash(3'(i));
                work_reg[i]  <= initial_hash(3'(i));
            end
            cnt_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                chain_reg[i] <= chain_next[i];
                work_reg[i]  <= work_next[i];
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WindowWords; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        digest_reg <= digest_next;
    end

    assign digest = digest_reg;

endmodule

// ----- design/sha256_message_digest.sv -----
// ----------------------------------------------------------------------------
// sha256_message_digest - SHA-256 hash over a byte stream
// Controller plus datapath; one compression round per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each transfer carries an optional
//   message byte (byte_present) and an optional end mark (end_of_message).
//   A transfer with neither does nothing. An end mark with no byte at the
//   start of a message hashes the empty string.
//   Output channel (out_valid / out_stall): one transfer per message, the
//   eight hash words, digest_word0 being the most significant.
// Timing:
//   Bytes are taken one per cycle until a 64-byte block is full; the block
//   then runs 64 rounds plus a chain update, with in_stall held high.
//   The single round unit sets the sustained rate: no bytes are taken
//   while a block is compressed. After the end mark, padding and length are
//   shifted in one byte a cycle, then one or two compressions follow,
//   depending on the final fill, before the digest is offered.
// Reset and stalls:
//   Reset loads the initial hash values and clears all counters; no
//   clearing pass is needed. The digest sits in its own register, so the
//   next message can stream in while the receiver stalls; only the next
//   digest waits until the previous one has been taken.
// ----------------------------------------------------------------------------
module sha256_message_digest
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word0,
    output logic [31:0] digest_word1,
    output logic [31:0] digest_word2,
    output logic [31:0] digest_word3,
    output logic [31:0] digest_word4,
    output logic [31:0] digest_word5,
    output logic [31:0] digest_word6,
    output logic [31:0] digest_word7
);

    cmd_t             cmd;
    logic [7:0][31:0] digest;

    // sequencing: block fill, padding, rounds, output handshake
    sha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cmd            (cmd)
    );

    // window, round logic, chaining state and digest register
    sha_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .digest    (digest)
    );

    assign digest_word0 = digest[0];
    assign digest_word1 = digest[1];
    assign digest_word2 = digest[2];
    assign digest_word3 = digest[3];
    assign digest_word4 = digest[4];
    assign digest_word5 = digest[5];
    assign digest_word6 = digest[6];
    assign digest_word7 = digest[7];

endmodule

// ----- design/sha_checker.sv -----
// ----------------------------------------------------------------------------
// sha_checker - port-level checks for the SHA-256 digest block
// Handshake stability and end-of-message sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module sha_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        end_of_message,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word0,
    input logic [31:0] digest_word7
);

    // a stalled digest stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("digest withdrawn while stalled");

    // a stalled digest holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(digest_word0) && $stable(digest_word7))
    else $error("digest changed while stalled");

    // an end-mark transfer starts padding, so input is held off next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && end_of_message |=> in_stall)
    else $error("input taken right after end of message");

    // a new digest only appears out of the busy finish sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("digest raised while collecting input");

endmodule

bind sha256_message_digest sha_checker u_sha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word0   (digest_word0),
    .digest_word7   (digest_word7)
);

// ----- test/sha256_message_digest_test.sv -----
// ----------------------------------------------------------------------------
// sha256_message_digest_test - self-checking bench for the SHA-256 digest block
// Streams byte messages of assorted lengths through the input channel and
// checks every digest word against a behavioral SHA-256 kept in the bench.
// Both channels see random idling, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module sha256_message_digest_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Eight hash words, index 0 is the most significant word of the digest.
    typedef logic [0:7][31:0] digest_t;

    // One input transfer as the bench plans it. wait_idle holds the transfer
    // back until every digest already owed has been taken.
    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        bit         wait_idle;
    } msg_item_t;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned TARGET_ITEMS = 850;
    localparam int unsigned HOLD_AT      = 450;   // transfers taken before the long hold
    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned TAIL_CYCLES  = 250;   // above the worst end-mark-to-digest latency
    localparam logic [7:0]  PAD_MARK     = 8'h80;

    localparam digest_t HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // ------------------------------------------------------------------------
    // DUT hookup. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte      = 8'h00;
    logic        byte_present   = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
    logic [31:0] digest_word5;
    logic [31:0] digest_word6;
    logic [31:0] digest_word7;

    sha256_message_digest u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word0   (digest_word0),
        .digest_word1   (digest_word1),
        .digest_word2   (digest_word2),
        .digest_word3   (digest_word3),
        .digest_word4   (digest_word4),
        .digest_word5   (digest_word5),
        .digest_word6   (digest_word6),
        .digest_word7   (digest_word7)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    msg_item_t   stim_items[$];        // transfers not yet offered
    digest_t     pending_digests[$];   // digests owed by the DUT, oldest first
    msg_item_t   next_item;
    bit          in_took      = 1'b0;  // input transfer at the last rising edge
    int unsigned items_taken  = 0;
    int unsigned digests_seen = 0;
    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_left    = 0;
    bit          hold_started = 1'b0;

    // Stimulus bookkeeping for the closing summary
    int unsigned msg_count    = 0;
    int unsigned empty_msgs   = 0;
    int unsigned two_blk_pads = 0;     // messages whose tail forces a second pad block
    int unsigned longest_msg  = 0;
    int unsigned filler_items = 0;
    int unsigned real_items   = 0;

    // Predictor state: chaining words, open block, fill and compressed bit count
    digest_t     hash_state = HASH_INIT;
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill   = 0;
    logic [63:0] bits_done  = '0;

    // ------------------------------------------------------------------------
    // SHA-256 predictor
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over blk_bytes, folded into hash_state.
    function automatic void compress_open_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, t1, t2;
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
            else
            begin
                s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
            s1 = rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_K[t] + w[t];
            s0 = rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    // Apply one accepted transfer; an end mark pads, finishes and queues the digest.
    function automatic void absorb_transfer(input logic [7:0] data, input logic has_byte,
                                            input logic last);
        int unsigned fill;
        logic [63:0] total_bits;
        if (has_byte)
        begin
            blk_bytes[blk_fill] = data;
            blk_fill++;
            if (blk_fill == 64)
            begin
                compress_open_block();
                bits_done += 64'd512;
                blk_fill = 0;
            end
        end
        if (last)
        begin
            fill = blk_fill;
            total_bits = bits_done + 64'(fill * 8);
            blk_bytes[fill] = PAD_MARK;
            for (int i = fill + 1; i < 64; i++)
                blk_bytes[i] = 8'h00;
            // no room for the length field: flush and pad a fresh block
            if (fill >= 56)
            begin
                compress_open_block();
                for (int i = 0; i < 64; i++)
                    blk_bytes[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                blk_bytes[63-i] = total_bits[8*i +: 8];
            compress_open_block();
            pending_digests.push_back(hash_state);
            hash_state = HASH_INIT;
            blk_fill   = 0;
            bits_done  = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %08h want %08h", $time, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Idling schedule, keyed on how many input transfers have gone through:
    // sender-light first, receiver-light next, then no idling at all.
    // ------------------------------------------------------------------------
    function automatic int unsigned send_idle_pct();
        if (items_taken < 300)
            return 30;
        else if (items_taken < 600)
            return 59;
        return 0;
    endfunction

    function automatic int unsigned recv_idle_pct();
        if (items_taken < 300)
            return 59;
        else if (items_taken < 600)
            return 30;
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [7:0] data, input logic has_byte, input logic last,
                             input bit wait_idle);
        msg_item_t it;
        it.data      = data;
        it.has_byte  = has_byte;
        it.last      = last;
        it.wait_idle = wait_idle;
        stim_items.push_back(it);
        if (has_byte || last)
            real_items++;
        else
            filler_items++;
    endtask

    // Mostly random bytes, with occasional all-zero and all-one bytes mixed in.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // One message of len bytes. The end mark rides on the last byte or, when
    // mark_alone is set (and always for an empty message), on a byteless transfer.
    // Occasional filler transfers (no byte, no mark) are scattered in between.
    task automatic add_message(input int unsigned len, input bit mark_alone,
                               input bit wait_idle);
        bit lone;
        lone = mark_alone || (len == 0);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 6)
                push_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            push_item(pick_byte(), 1'b1, !lone && (i == len - 1), wait_idle && (i == 0));
        end
        if (lone)
            push_item(8'($urandom), 1'b0, 1'b1, wait_idle && (len == 0));
        msg_count++;
        if (len == 0)
            empty_msgs++;
        if (len % 64 >= 56)
            two_blk_pads++;
        if (len > longest_msg)
            longest_msg = len;
    endtask

    function automatic int unsigned pick_length();
        int unsigned edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(20, 1);
        else if (roll < 85)
            return edges[$urandom_range(9)];
        else if (roll < 93)
            return 0;
        return $urandom_range(140, 21);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: new payload at the falling edge once the previous one has moved.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct()
                && !(stim_items[0].wait_idle && pending_digests.size() != 0))
            begin
                next_item = stim_items.pop_front();
                in_valid       <= 1'b1;
                data_byte      <= next_item.data;
                byte_present   <= next_item.has_byte;
                end_of_message <= next_item.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall. The long hold is counted here; the sender keeps going,
    // so the digest register fills and the DUT has to push back on its input.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!hold_started && items_taken >= HOLD_AT)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct());
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        digest_t got;
        digest_t want;
        in_took = rst_n && in_valid && !in_stall;
        if (in_took)
        begin
            absorb_transfer(data_byte, byte_present, end_of_message);
            items_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = {digest_word0, digest_word1, digest_word2, digest_word3,
                   digest_word4, digest_word5, digest_word6, digest_word7};
            digests_seen++;
            if (pending_digests.size() == 0)
                report_mismatch("digest with none owed, word0", got[0], 32'h0);
            else
            begin
                want = pending_digests.pop_front();
                for (int i = 0; i < 8; i++)
                    if (got[i] !== want[i])
                        report_mismatch($sformatf("digest %0d digest_word%0d", digests_seen, i),
                                        got[i], want[i]);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digests owed", cycle_count,
                     pending_digests.size());
            $display("sha256_message_digest_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed messages, random messages, drain, verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        // Directed: empty message, filler alone, "abc", single extreme bytes,
        // end mark after bytes on its own, back-to-back empties, pad byte as data.
        add_message(0, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b1, 1'b0);
        msg_count++;
        push_item(8'h00, 1'b1, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b1, 1'b0);
        push_item(8'ha5, 1'b1, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0, 1'b0);
        push_item(8'h5a, 1'b1, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1, 1'b0);
        msg_count += 3;
        add_message(0, 1'b1, 1'b0);
        add_message(0, 1'b1, 1'b1);
        push_item(8'h80, 1'b1, 1'b1, 1'b0);
        msg_count++;

        // Random messages; every ninth one waits for the DUT to drain first.
        while (real_items < TARGET_ITEMS)
            add_message(pick_length(), $urandom_range(1), (msg_count % 9) == 4);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_items.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d messages (%0d empty, %0d with a second pad block, longest %0d B)",
                 msg_count, empty_msgs, two_blk_pads, longest_msg);
        $display("%0d transfers in, %0d filler, %0d digests checked, %0d cycles",
                 items_taken, filler_items, digests_seen, cycle_count);
        if (err_count == 0)
            $display("sha256_message_digest_test: clean");
        else
            $display("sha256_message_digest_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sha_pkg.sv
design/sha_ctrl.sv
design/sha_datapath.sv
design/sha256_message_digest.sv
design/sha_checker.sv
test/sha256_message_digest_test.sv
